>>> design/rwtf_pkg.sv
// Register write trace filter: shared types and constants.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package rwtf_pkg;

    localparam int SHADOW_DEPTH = 256;
    localparam int ADDR_W       = $clog2(SHADOW_DEPTH);
    localparam int ROW_W        = ADDR_W - 1;
    localparam int POS_W        = 17;

    localparam logic [2:0] MODE_REG        = 3'd0;
    localparam logic [2:0] MODE_PITCH      = 3'd1;
    localparam logic [2:0] MODE_LOOP       = 3'd2;
    localparam logic [2:0] MODE_BEGIN      = 3'd3;
    localparam logic [2:0] MODE_END        = 3'd4;
    localparam logic [2:0] MODE_INIT_BEGIN = 3'd5;
    localparam logic [2:0] MODE_INIT_END   = 3'd6;

    localparam logic [7:0] FORCED_REG_A  = 8'h4C;
    localparam logic [7:0] FORCED_REG_B  = 8'h5C;
    localparam logic [7:0] END_MARKER    = 8'h9E;
    localparam logic [7:0] SINGLE_LIMIT  = 8'd128;
    localparam logic [3:0] PITCH_NIBBLE  = 4'h2;

    localparam logic [1:0] LEN_END    = 2'd1;
    localparam logic [1:0] LEN_SINGLE = 2'd2;
    localparam logic [1:0] LEN_PAIR   = 2'd3;

    localparam logic [POS_W-1:0] MAX_LOG_ENTRIES = 17'd65536;
    localparam logic [POS_W-1:0] CAP_RESET       = 17'd65536;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  reg_addr;
        logic [7:0]  low_byte;
        logic [7:0]  high_byte;
        logic [30:0] sample_time;
    } t_req;

    typedef struct packed {
        logic             we;
        logic [ROW_W-1:0] row;
        logic [7:0]       data;
    } t_bank_wr;

    typedef struct packed {
        logic             accepted;
        logic             log_valid;
        logic [1:0]       entry_length;
        logic [7:0]       entry_first;
        logic [7:0]       entry_second;
        logic [7:0]       entry_third;
        logic [30:0]      entry_stamp;
        logic [15:0]      entry_index;
        logic [POS_W-1:0] loop_index;
        logic [POS_W-1:0] init_start_index;
        logic [POS_W-1:0] init_stop_index;
    } t_rslt;

endpackage

`default_nettype wire

>>> design/register_write_trace_filter_top.sv
// Register write trace filter, top level.
// Depends on rwtf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one request per clock when the output is not stalled and returns one result per
// request from the result register. The first stage registers the request
// and reads the register shadow, kept as two 128 x 8 banks of even and odd
// addresses so that both halves of a pitch pair are read and written together. The second
// stage compares against the shadow, updates it and the log counters, and fills
// the result register. Shadow known bits are flip-flops cleared by reset, loop mark
// and begin dump, so no clearing pass follows reset. log_capacity may be written
// only while no request is in flight.
module register_write_trace_filter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [16:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_mode,
    input  wire logic [7:0]  i_reg_addr,
    input  wire logic [7:0]  i_low_byte,
    input  wire logic [7:0]  i_high_byte,
    input  wire logic [30:0] i_sample_time,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_accepted,
    output logic             o_log_valid,
    output logic [1:0]       o_entry_length,
    output logic [7:0]       o_entry_first,
    output logic [7:0]       o_entry_second,
    output logic [7:0]       o_entry_third,
    output logic [30:0]      o_entry_stamp,
    output logic [15:0]      o_entry_index,
    output logic [16:0]      o_loop_index,
    output logic [16:0]      o_init_start_index,
    output logic [16:0]      o_init_stop_index
);
    import rwtf_pkg::*;

    localparam int ROWS = SHADOW_DEPTH / 2;

    logic [7:0] mem_ev [ROWS];
    logic [7:0] mem_od [ROWS];

    logic                    r_s1_vld;
    t_req                    r_req;
    logic [7:0]              r_rd_ev;
    logic [7:0]              r_rd_od;
    t_bank_wr                r_byp_ev;
    t_bank_wr                r_byp_od;
    logic [SHADOW_DEPTH-1:0] r_known;
    logic [POS_W-1:0]        r_log_pos;
    logic [POS_W-1:0]        r_loop_pos;
    logic [POS_W-1:0]        r_init_start;
    logic [POS_W-1:0]        r_init_stop;
    logic                    r_end_logged;
    logic [POS_W-1:0]        r_cap;
    logic                    r_out_vld;
    t_rslt                   r_out;

    logic                    out_free;
    logic                    move;
    logic                    accept;
    logic [ROW_W-1:0]        row;
    logic [ADDR_W-1:0]       up_addr;
    logic [7:0]              ev_val;
    logic [7:0]              od_val;
    logic [7:0]              cur_val;
    logic                    known_lo;
    logic                    known_up;
    logic                    forced;
    logic                    single_ok;
    logic                    hi_same;
    logic                    pitch_ok;
    logic [POS_W-1:0]        eff_cap;
    logic                    room;

    logic                    do_single;
    logic                    do_pair;
    logic                    emit;
    logic [1:0]              e_len;
    logic [7:0]              e_first;
    logic [7:0]              e_second;
    logic [7:0]              e_third;
    t_bank_wr                wr_ev;
    t_bank_wr                wr_od;
    logic [SHADOW_DEPTH-1:0] n_known;
    logic [POS_W-1:0]        n_log_pos;
    logic [POS_W-1:0]        n_loop_pos;
    logic [POS_W-1:0]        n_init_start;
    logic [POS_W-1:0]        n_init_stop;
    logic                    n_end_logged;
    t_rslt                   n_rslt;

    assign out_free = !r_out_vld || !i_stall;
    assign move     = r_s1_vld && out_free;
    assign o_stall  = r_s1_vld && !out_free;
    assign accept   = i_valid && !o_stall;

    assign row      = r_req.reg_addr[ADDR_W-1:1];
    assign up_addr  = {row, 1'b1};
    assign ev_val   = (r_byp_ev.we && r_byp_ev.row == row) ? r_byp_ev.data : r_rd_ev;
    assign od_val   = (r_byp_od.we && r_byp_od.row == row) ? r_byp_od.data : r_rd_od;
    assign cur_val  = r_req.reg_addr[0] ? od_val : ev_val;
    assign known_lo = r_known[r_req.reg_addr];
    assign known_up = r_known[up_addr];
    assign forced   = (r_req.reg_addr == FORCED_REG_A) || (r_req.reg_addr == FORCED_REG_B);
    assign single_ok = (r_req.reg_addr < SINGLE_LIMIT)
                       && !(known_lo && cur_val == r_req.low_byte && !forced);
    assign hi_same  = known_up && od_val == r_req.high_byte;
    assign pitch_ok = r_req.reg_addr[3:0] == PITCH_NIBBLE;
    assign eff_cap  = (r_cap > MAX_LOG_ENTRIES) ? MAX_LOG_ENTRIES : r_cap;
    assign room     = r_log_pos < eff_cap;

    always_comb begin
        do_single    = 1'b0;
        do_pair      = 1'b0;
        emit         = 1'b0;
        e_len        = '0;
        e_first      = '0;
        e_second     = '0;
        e_third      = '0;
        wr_ev        = '0;
        wr_od        = '0;
        n_known      = r_known;
        n_log_pos    = r_log_pos;
        n_loop_pos   = r_loop_pos;
        n_init_start = r_init_start;
        n_init_stop  = r_init_stop;
        n_end_logged = r_end_logged;
        n_rslt       = '0;

        case (r_req.mode)
            MODE_REG: begin
                do_single = single_ok;
            end
            MODE_PITCH: begin
                if (pitch_ok) begin
                    if (hi_same) begin
                        do_single = single_ok;
                    end else begin
                        do_pair = 1'b1;
                    end
                end
            end
            MODE_LOOP: begin
                n_loop_pos = r_log_pos;
                n_known    = '0;
            end
            MODE_BEGIN: begin
                n_log_pos    = '0;
                n_loop_pos   = '0;
                n_init_start = '0;
                n_init_stop  = '0;
                n_known      = '0;
                n_end_logged = 1'b0;
            end
            MODE_END: begin
                if (room && !r_end_logged) begin
                    emit         = 1'b1;
                    e_len        = LEN_END;
                    e_first      = END_MARKER;
                    n_end_logged = 1'b1;
                end
            end
            MODE_INIT_BEGIN: begin
                n_init_start = r_log_pos;
            end
            MODE_INIT_END: begin
                n_init_stop = r_log_pos;
            end
            default: begin
            end
        endcase

        if (do_single) begin
            n_known[r_req.reg_addr] = 1'b1;
            if (r_req.reg_addr[0]) begin
                wr_od = '{we: 1'b1, row: row, data: r_req.low_byte};
            end else begin
                wr_ev = '{we: 1'b1, row: row, data: r_req.low_byte};
            end
            if (room) begin
                emit     = 1'b1;
                e_len    = LEN_SINGLE;
                e_first  = r_req.reg_addr;
                e_second = r_req.low_byte;
            end
        end

        if (do_pair) begin
            n_known[r_req.reg_addr] = 1'b1;
            n_known[up_addr]        = 1'b1;
            wr_ev = '{we: 1'b1, row: row, data: r_req.low_byte};
            wr_od = '{we: 1'b1, row: row, data: r_req.high_byte};
            if (room) begin
                emit     = 1'b1;
                e_len    = LEN_PAIR;
                e_first  = up_addr;
                e_second = r_req.high_byte;
                e_third  = r_req.low_byte;
            end
        end

        if (emit) begin
            n_log_pos           = r_log_pos + 17'd1;
            n_rslt.log_valid    = 1'b1;
            n_rslt.entry_length = e_len;
            n_rslt.entry_first  = e_first;
            n_rslt.entry_second = e_second;
            n_rslt.entry_third  = e_third;
            n_rslt.entry_stamp  = r_req.sample_time;
            n_rslt.entry_index  = r_log_pos[15:0];
        end

        n_rslt.accepted         = do_single || do_pair;
        n_rslt.loop_index       = n_loop_pos;
        n_rslt.init_start_index = n_init_start;
        n_rslt.init_stop_index  = n_init_stop;
    end

    // Shadow banks: write on commit, read on accept.
    always_ff @(posedge i_clk) begin
        if (move && wr_ev.we) begin
            mem_ev[wr_ev.row] <= wr_ev.data;
        end
        if (move && wr_od.we) begin
            mem_od[wr_od.row] <= wr_od.data;
        end
        if (accept) begin
            r_rd_ev <= mem_ev[i_reg_addr[ADDR_W-1:1]];
            r_rd_od <= mem_od[i_reg_addr[ADDR_W-1:1]];
        end
    end

    // Hold the request and the writes that land in the same cycle as its read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= '{mode: i_mode, reg_addr: i_reg_addr, low_byte: i_low_byte,
                          high_byte: i_high_byte, sample_time: i_sample_time};
            r_byp_ev <= '{we: wr_ev.we && move, row: wr_ev.row, data: wr_ev.data};
            r_byp_od <= '{we: wr_od.we && move, row: wr_od.row, data: wr_od.data};
        end
        if (move) begin
            r_out <= n_rslt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_known      <= '0;
            r_log_pos    <= '0;
            r_loop_pos   <= '0;
            r_init_start <= '0;
            r_init_stop  <= '0;
            r_end_logged <= 1'b0;
            r_cap        <= CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (move) begin
                r_s1_vld <= 1'b0;
            end
            if (move) begin
                r_out_vld    <= 1'b1;
                r_known      <= n_known;
                r_log_pos    <= n_log_pos;
                r_loop_pos   <= n_loop_pos;
                r_init_start <= n_init_start;
                r_init_stop  <= n_init_stop;
                r_end_logged <= n_end_logged;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid            = r_out_vld;
    assign o_accepted         = r_out.accepted;
    assign o_log_valid        = r_out.log_valid;
    assign o_entry_length     = r_out.entry_length;
    assign o_entry_first      = r_out.entry_first;
    assign o_entry_second     = r_out.entry_second;
    assign o_entry_third      = r_out.entry_third;
    assign o_entry_stamp      = r_out.entry_stamp;
    assign o_entry_index      = r_out.entry_index;
    assign o_loop_index       = r_out.loop_index;
    assign o_init_start_index = r_out.init_start_index;
    assign o_init_stop_index  = r_out.init_stop_index;

endmodule

`default_nettype wire

>>> design/rwtf_checker.sv
// Port-level checker for the register write trace filter, with its bind.
// Depends on rwtf_pkg and register_write_trace_filter_top.
`timescale 1ns / 1ps
`default_nettype none

module rwtf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_accepted,
    input wire logic        o_log_valid,
    input wire logic [1:0]  o_entry_length,
    input wire logic [7:0]  o_entry_first,
    input wire logic [15:0] o_entry_index
);
    import rwtf_pkg::*;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_entry_first) && $stable(o_entry_index))
        else $error("stalled result changed");

    a_entry_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_log_valid |-> o_accepted || o_entry_length == LEN_END)
        else $error("write entry logged without acceptance");

    a_empty_entry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_log_valid |-> o_entry_length == 2'd0 && o_entry_index == 16'd0)
        else $error("non-logged result carries entry fields");

    a_pair_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_log_valid && o_entry_length == LEN_PAIR |-> o_entry_first[3:0] == 4'h3)
        else $error("pitch pair entry with wrong high register");

endmodule

bind register_write_trace_filter_top rwtf_checker u_rwtf_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for the register write trace filter top level.
// Uses rwtf_pkg and register_write_trace_filter_top; runs stand-alone.
`timescale 1ns / 1ps

module testbench;
    import rwtf_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [16:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_mode = '0;
    logic [7:0]  i_reg_addr = '0;
    logic [7:0]  i_low_byte = '0;
    logic [7:0]  i_high_byte = '0;
    logic [30:0] i_sample_time = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_accepted;
    logic        o_log_valid;
    logic [1:0]  o_entry_length;
    logic [7:0]  o_entry_first;
    logic [7:0]  o_entry_second;
    logic [7:0]  o_entry_third;
    logic [30:0] o_entry_stamp;
    logic [15:0] o_entry_index;
    logic [16:0] o_loop_index;
    logic [16:0] o_init_start_index;
    logic [16:0] o_init_stop_index;

    register_write_trace_filter_top u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_reg_addr        (i_reg_addr),
        .i_low_byte        (i_low_byte),
        .i_high_byte       (i_high_byte),
        .i_sample_time     (i_sample_time),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_accepted        (o_accepted),
        .o_log_valid       (o_log_valid),
        .o_entry_length    (o_entry_length),
        .o_entry_first     (o_entry_first),
        .o_entry_second    (o_entry_second),
        .o_entry_third     (o_entry_third),
        .o_entry_stamp     (o_entry_stamp),
        .o_entry_index     (o_entry_index),
        .o_loop_index      (o_loop_index),
        .o_init_start_index(o_init_start_index),
        .o_init_stop_index (o_init_stop_index)
    );

    // filter state mirror
    logic [7:0]       shadow_val [SHADOW_DEPTH];
    logic             shadow_ok  [SHADOW_DEPTH];
    logic [POS_W-1:0] log_pos;
    logic [POS_W-1:0] loop_pos;
    logic [POS_W-1:0] init_start_pos;
    logic [POS_W-1:0] init_stop_pos;
    logic [POS_W-1:0] log_cap;
    logic             end_done;
    t_rslt            next_trace;

    t_rslt trace_queue [$];
    int    tx_idle_pct = 0;
    int    rx_idle_pct = 0;
    int    mismatches = 0;
    int    requests_sent = 0;
    int    writes_taken = 0;
    int    entries_logged = 0;
    int    cycle_count = 0;

    always #2 i_clk = ~i_clk;

    function automatic logic has_room();
        logic [POS_W-1:0] cap;
        cap = (log_cap > MAX_LOG_ENTRIES) ? MAX_LOG_ENTRIES : log_cap;
        return log_pos < cap;
    endfunction

    function automatic void forget_shadow();
        for (int k = 0; k < SHADOW_DEPTH; k++) shadow_ok[k] = 1'b0;
    endfunction

    function automatic void append_entry(logic [1:0] len, logic [7:0] a, logic [7:0] b,
                                         logic [7:0] c, logic [30:0] stamp);
        next_trace.log_valid    = 1'b1;
        next_trace.entry_length = len;
        next_trace.entry_first  = a;
        next_trace.entry_second = b;
        next_trace.entry_third  = c;
        next_trace.entry_stamp  = stamp;
        next_trace.entry_index  = log_pos[15:0];
        log_pos = log_pos + 17'd1;
    endfunction

    function automatic logic filter_single(logic [7:0] addr, logic [7:0] data,
                                          logic [30:0] stamp);
        if (addr >= SINGLE_LIMIT) return 1'b0;
        if (shadow_ok[addr] && shadow_val[addr] == data &&
            addr != FORCED_REG_A && addr != FORCED_REG_B) return 1'b0;
        shadow_val[addr] = data;
        shadow_ok[addr] = 1'b1;
        if (has_room()) append_entry(LEN_SINGLE, addr, data, 8'h00, stamp);
        return 1'b1;
    endfunction

    function automatic logic filter_pitch(logic [7:0] addr, logic [7:0] lo, logic [7:0] hi,
                                         logic [30:0] stamp);
        logic [7:0] up;
        if (addr[3:0] != PITCH_NIBBLE) return 1'b0;
        up = addr + 8'd1;
        if (shadow_ok[up] && shadow_val[up] == hi) return filter_single(addr, lo, stamp);
        shadow_val[addr] = lo;
        shadow_ok[addr] = 1'b1;
        shadow_val[up] = hi;
        shadow_ok[up] = 1'b1;
        if (has_room()) append_entry(LEN_PAIR, up, hi, lo, stamp);
        return 1'b1;
    endfunction

    function automatic void clear_trace_state();
        log_pos = '0;
        loop_pos = '0;
        init_start_pos = '0;
        init_stop_pos = '0;
        end_done = 1'b0;
        forget_shadow();
    endfunction

    function automatic t_rslt filter_trace(t_req req);
        logic acc;
        acc = 1'b0;
        next_trace = '0;
        case (req.mode)
            MODE_REG: begin
                acc = filter_single(req.reg_addr, req.low_byte, req.sample_time);
            end
            MODE_PITCH: begin
                acc = filter_pitch(req.reg_addr, req.low_byte, req.high_byte,
                                   req.sample_time);
            end
            MODE_LOOP: begin
                loop_pos = log_pos;
                forget_shadow();
            end
            MODE_BEGIN: begin
                clear_trace_state();
            end
            MODE_END: begin
                if (has_room() && !end_done) begin
                    append_entry(LEN_END, END_MARKER, 8'h00, 8'h00, req.sample_time);
                    end_done = 1'b1;
                end
            end
            MODE_INIT_BEGIN: init_start_pos = log_pos;
            MODE_INIT_END:   init_stop_pos = log_pos;
            default: ;
        endcase
        next_trace.accepted = acc;
        next_trace.loop_index = loop_pos;
        next_trace.init_start_index = init_start_pos;
        next_trace.init_stop_index = init_stop_pos;
        return next_trace;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        t_rslt want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, trace_queue.size());
            $display("[register_write_trace_filter_top] ERROR");
            $finish;
        end else if (i_rst_n && o_valid && !i_stall) begin
            if (trace_queue.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing outstanding", $time);
            end else begin
                want = trace_queue.pop_front();
                check_field("accepted", 32'(want.accepted), 32'(o_accepted));
                check_field("log_valid", 32'(want.log_valid), 32'(o_log_valid));
                check_field("entry_length", 32'(want.entry_length), 32'(o_entry_length));
                check_field("entry_first", 32'(want.entry_first), 32'(o_entry_first));
                check_field("entry_second", 32'(want.entry_second), 32'(o_entry_second));
                check_field("entry_third", 32'(want.entry_third), 32'(o_entry_third));
                check_field("entry_stamp", 32'(want.entry_stamp), 32'(o_entry_stamp));
                check_field("entry_index", 32'(want.entry_index), 32'(o_entry_index));
                check_field("loop_index", 32'(want.loop_index), 32'(o_loop_index));
                check_field("init_start_index", 32'(want.init_start_index),
                            32'(o_init_start_index));
                check_field("init_stop_index", 32'(want.init_stop_index),
                            32'(o_init_stop_index));
            end
        end
    end

    task automatic send_req(logic [2:0] mode, logic [7:0] addr, logic [7:0] lo,
                            logic [7:0] hi, logic [30:0] stamp);
        t_req req;
        t_rslt res;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req = '{mode: mode, reg_addr: addr, low_byte: lo, high_byte: hi, sample_time: stamp};
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_reg_addr    <= addr;
        i_low_byte    <= lo;
        i_high_byte   <= hi;
        i_sample_time <= stamp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        res = filter_trace(req);
        trace_queue.push_back(res);
        requests_sent++;
        if (res.accepted) writes_taken++;
        if (res.log_valid) entries_logged++;
    endtask

    // hold requests until every result is back, then let the pipeline settle
    task automatic drain_trace();
        i_valid <= 1'b0;
        while (trace_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_capacity(logic [16:0] cap);
        drain_trace();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        log_cap = cap;
    endtask

    task automatic test_single_writes();
        send_req(MODE_REG, 8'h00, 8'h00, 8'h00, 31'd0);
        send_req(MODE_REG, 8'h00, 8'h00, 8'hFF, 31'd1);
        send_req(MODE_REG, 8'h7F, 8'hFF, 8'h00, 31'h7FFFFFFF);
        send_req(MODE_REG, 8'h80, 8'h12, 8'h00, 31'd3);
        send_req(MODE_REG, 8'hFF, 8'h34, 8'h00, 31'd4);
        send_req(MODE_REG, FORCED_REG_A, 8'h11, 8'h00, 31'd5);
        send_req(MODE_REG, FORCED_REG_A, 8'h11, 8'h00, 31'd6);
        send_req(MODE_REG, FORCED_REG_B, 8'h22, 8'h00, 31'd7);
    endtask

    task automatic test_pitch_writes();
        send_req(MODE_PITCH, 8'h02, 8'h10, 8'hFF, 31'd10);
        send_req(MODE_PITCH, 8'h02, 8'h11, 8'hFF, 31'd11);
        send_req(MODE_PITCH, 8'h02, 8'h11, 8'hFF, 31'd12);
        send_req(MODE_PITCH, 8'h13, 8'h01, 8'h02, 31'd13);
        send_req(MODE_PITCH, 8'h82, 8'h01, 8'h02, 31'd14);
        send_req(MODE_PITCH, 8'h82, 8'h03, 8'h02, 31'd15);
        send_req(MODE_PITCH, 8'hF2, 8'hAA, 8'h55, 31'd16);
    endtask

    task automatic test_marks();
        send_req(MODE_LOOP, 8'h00, 8'h00, 8'h00, 31'd20);
        send_req(MODE_INIT_BEGIN, 8'h00, 8'h00, 8'h00, 31'd21);
        send_req(MODE_END, 8'h00, 8'h00, 8'h00, 31'd22);
        send_req(MODE_END, 8'h00, 8'h00, 8'h00, 31'd23);
        send_req(3'd7, 8'hFF, 8'hFF, 8'hFF, 31'h7FFFFFFF);
        send_req(MODE_INIT_END, 8'h00, 8'h00, 8'h00, 31'd25);
        send_req(MODE_BEGIN, 8'h00, 8'h00, 8'h00, 31'd26);
    endtask

    task automatic test_capacity();
        set_capacity(17'd2);
        send_req(MODE_BEGIN, 8'h00, 8'h00, 8'h00, 31'd30);
        send_req(MODE_REG, 8'h01, 8'h01, 8'h00, 31'd31);
        send_req(MODE_REG, 8'h01, 8'h02, 8'h00, 31'd32);
        send_req(MODE_REG, 8'h01, 8'h03, 8'h00, 31'd33);
        send_req(MODE_END, 8'h00, 8'h00, 8'h00, 31'd34);
        set_capacity(17'd0);
        send_req(MODE_BEGIN, 8'h00, 8'h00, 8'h00, 31'd35);
        send_req(MODE_PITCH, 8'h22, 8'h01, 8'h02, 31'd36);
        send_req(MODE_END, 8'h00, 8'h00, 8'h00, 31'd37);
    endtask

    task automatic send_random_req();
        int pick;
        logic [2:0] mode;
        logic [7:0] addr;
        logic [7:0] lo;
        logic [7:0] hi;
        pick = $urandom_range(0, 99);
        lo = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        hi = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
        case ($urandom_range(0, 4))
            0: addr = 8'($urandom_range(0, 15));
            1: addr = $urandom_range(0, 1) ? FORCED_REG_A : FORCED_REG_B;
            2: addr = 8'($urandom_range(112, 127));
            3: addr = {4'($urandom_range(0, 2)), 4'($urandom)};
            default: addr = 8'($urandom);
        endcase
        if (pick < 45) begin
            mode = MODE_REG;
        end else if (pick < 75) begin
            mode = MODE_PITCH;
            if ($urandom_range(0, 9) != 0) addr = {addr[7:4], PITCH_NIBBLE};
        end else if (pick < 79) begin
            mode = MODE_LOOP;
        end else if (pick < 83) begin
            mode = MODE_BEGIN;
        end else if (pick < 88) begin
            mode = MODE_END;
        end else if (pick < 92) begin
            mode = MODE_INIT_BEGIN;
        end else if (pick < 96) begin
            mode = MODE_INIT_END;
        end else begin
            mode = 3'($urandom);
        end
        send_req(mode, addr, lo, hi, 31'($urandom));
    endtask

    task automatic test_random(int count, int tx_pct, int rx_pct, logic [16:0] cap);
        set_capacity(cap);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) drain_trace();
            send_random_req();
        end
    endtask

    initial begin
        for (int k = 0; k < SHADOW_DEPTH; k++) shadow_val[k] = 8'h00;
        clear_trace_state();
        log_cap = CAP_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_writes();
        test_pitch_writes();
        test_marks();
        test_capacity();
        test_random(230, 11, 58, 17'h1FFFF);
        test_random(230, 58, 11, 17'($urandom_range(8, 40)));
        test_random(240, 0, 0, CAP_RESET);

        drain_trace();
        repeat (8) @(posedge i_clk);
        $display("%0d requests across directed, capacity and three random stall mixes",
                 requests_sent);
        $display("%0d writes accepted, %0d trace entries logged", writes_taken,
                 entries_logged);
        if (mismatches == 0) begin
            $display("[register_write_trace_filter_top] OK");
        end else begin
            $display("[register_write_trace_filter_top] ERROR");
        end
        $finish;
    end

endmodule
